// ===== hdl/nfc_type4_tag_apdu_responder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// NFC Type 4 tag responder - assertion macros
// Shared property shapes for the port checker. The enclosing scope must
// provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef NFC_TYPE4_TAG_APDU_RESPONDER_UNIT_DEFINES_SVH
`define NFC_TYPE4_TAG_APDU_RESPONDER_UNIT_DEFINES_SVH

// Check that a condition implies another condition in the same cycle
`define NFC4_ASSERT_SAME(label, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_now)) else $error("nfc4 check failed");

// Check that a condition implies another condition in the next cycle
`define NFC4_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error("nfc4 check failed");

`endif

// ===== hdl/nfc4_pkg.sv =====
// ----------------------------------------------------------------------------
// nfc4_pkg
// Types, constants, ROM contents and lookup functions shared by the
// ISO-DEP / Type 4 tag responder.
// ----------------------------------------------------------------------------
package nfc4_pkg;

    // Reply buffer size; a read may return at most REPLY_BYTES - 3 data words
    localparam int REPLY_BYTES = 64;

    // Frame position counter saturates once the application id has been seen
    localparam int          POS_W      = 4;
    localparam logic [3:0]  POS_HDR    = 4'd6;
    localparam logic [3:0]  POS_ID_END = 4'd8;
    localparam logic [3:0]  POS_AID_END = 4'd13;

    localparam int QUEUE_DEPTH = 2;

    // PCB classification masks and values
    localparam logic [7:0] PCB_I_MASK = 8'he2;
    localparam logic [7:0] PCB_I_VAL  = 8'h02;
    localparam logic [7:0] PCB_R_MASK = 8'he6;
    localparam logic [7:0] PCB_R_VAL  = 8'ha2;
    localparam logic [7:0] PCB_S_MASK = 8'hc7;
    localparam logic [7:0] PCB_S_VAL  = 8'hc2;
    localparam logic [7:0] PCB_R_ACK  = 8'ha2;

    // APDU codes
    localparam logic [7:0] CLA_ISO      = 8'h00;
    localparam logic [7:0] INS_SELECT   = 8'ha4;
    localparam logic [7:0] INS_READ_BIN = 8'hb0;
    localparam logic [7:0] P1_BY_NAME   = 8'h04;
    localparam logic [7:0] P2_BY_NAME   = 8'h00;
    localparam logic [7:0] P1_BY_ID     = 8'h00;
    localparam logic [7:0] P2_BY_ID     = 8'h0c;
    localparam logic [7:0] LC_AID       = 8'd7;
    localparam logic [7:0] LC_FILE_ID   = 8'd2;

    // File ids
    localparam logic [7:0] CAP_ID_HI  = 8'he1;
    localparam logic [7:0] CAP_ID_LO  = 8'h03;
    localparam logic [7:0] NDEF_ID_HI = 8'h00;
    localparam logic [7:0] NDEF_ID_LO = 8'h01;

    // Status words
    localparam logic [7:0] SW_OK_HI       = 8'h90;
    localparam logic [7:0] SW_NOT_FOUND   = 8'h6a;
    localparam logic [7:0] SW_NOT_FOUND_LO = 8'h82;
    localparam logic [7:0] SW_BAD_LEN     = 8'h67;
    localparam logic [7:0] SW_BAD_P1P2    = 8'h6b;
    localparam logic [7:0] SW_BAD_INS     = 8'h6d;
    localparam logic [7:0] SW_BAD_CLA     = 8'h6e;
    localparam logic [7:0] SW_ZERO        = 8'h00;

    // ROM files
    localparam int CC_LEN   = 15;
    localparam int NDEF_LEN = 44;

    localparam logic [7:0] CC_ROM [CC_LEN] = '{
        8'h00, 8'h0f, 8'h20, 8'h00, 8'hff, 8'h00, 8'h36,
        8'h04, 8'h06, 8'h00, 8'h01, 8'h00, 8'h2c, 8'h00, 8'hff
    };

    localparam logic [7:0] NDEF_ROM [NDEF_LEN] = '{
        8'h00, 8'h2a,
        8'hd1, 8'h01, 8'h26, 8'h55, 8'h04, 8'h67, 8'h69, 8'h74, 8'h68, 8'h75,
        8'h62, 8'h2e, 8'h63, 8'h6f, 8'h6d, 8'h2f,
        8'h67, 8'h65, 8'h6e, 8'h74, 8'h69, 8'h6c, 8'h6b, 8'h69, 8'h77, 8'h69,
        8'h2f, 8'h73, 8'h74, 8'h32, 8'h35, 8'h74,
        8'h62, 8'h5f, 8'h6b, 8'h61, 8'h6d, 8'h65, 8'h6c, 8'h65, 8'h6f, 8'h6e
    };

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_CC   = 2'd1,
        SEL_NDEF = 2'd2
    } sel_t;

    typedef enum logic {
        RK_SINGLE = 1'b0,
        RK_APDU   = 1'b1
    } reply_kind_t;

    // One queued reply: PCB word, optional ROM data run, status word
    typedef struct packed {
        reply_kind_t kind;
        logic [7:0]  pcb;
        logic [7:0]  sw_hi;
        logic [7:0]  sw_lo;
        logic        rom_ndef;
        logic [5:0]  offset;
        logic [5:0]  length;
    } reply_t;

    typedef enum logic {
        FR_RECV     = 1'b0,
        FR_CLASSIFY = 1'b1
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_PCB   = 3'd1,
        BK_DATA  = 3'd2,
        BK_SW_HI = 3'd3,
        BK_SW_LO = 3'd4
    } back_state_t;

    // NDEF application id, one word per position
    function automatic logic [7:0] aid_byte(input logic [2:0] idx);
        logic [7:0] result;
        case (idx)
            3'd0:    result = 8'hd2;
            3'd1:    result = 8'h76;
            3'd2:    result = 8'h00;
            3'd3:    result = 8'h00;
            3'd4:    result = 8'h85;
            3'd5:    result = 8'h01;
            3'd6:    result = 8'h01;
            default: result = 8'h00;
        endcase
        return result;
    endfunction

    // File contents lookup
    function automatic logic [7:0] rom_byte(input logic ndef, input logic [5:0] addr);
        logic [7:0] result;
        result = 8'h00;
        if (ndef)
        begin
            if (addr < 6'(NDEF_LEN))
            begin
                result = NDEF_ROM[addr];
            end
        end
        else if (addr < 6'(CC_LEN))
        begin
            result = CC_ROM[addr[3:0]];
        end
        return result;
    endfunction

endpackage

// ===== hdl/nfc4_rx_if.sv =====
// ----------------------------------------------------------------------------
// nfc4_rx_if
// Received frame word channel: one frame word with its end-of-frame mark.
// ----------------------------------------------------------------------------
interface nfc4_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

// ===== hdl/nfc4_tx_if.sv =====
// ----------------------------------------------------------------------------
// nfc4_tx_if
// Reply frame word channel: one reply word with its end-of-frame mark.
// ----------------------------------------------------------------------------
interface nfc4_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ===== hdl/nfc4_front.sv =====
// ----------------------------------------------------------------------------
// nfc4_front
// Frame parser: collects header words and id match flags, then sorts the
// finished frame into a reply descriptor and pushes it to the queue when a reply is needed.
// ----------------------------------------------------------------------------
module nfc4_front
    import nfc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    nfc4_rx_if.sink     rx,
    output logic        push_valid,
    input  logic        push_ready,
    output reply_t      push_data
);

    front_state_t      state_reg, state_next;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        hdr_reg [6];
    logic              aid_eq_reg;
    logic              cap_reg;
    logic              ndef_reg;
    sel_t              sel_reg;

    logic              rx_fire;
    logic              need_reply;
    logic              sel_write;
    sel_t              sel_value;
    reply_t            desc;
    logic              done;

    logic [7:0]        pcb, cla, ins, p1, p2, lc;
    logic [16:0]       read_end;
    logic [16:0]       file_len;

    assign rx_fire = rx.valid && rx.ready;
    assign pcb = hdr_reg[0];
    assign cla = hdr_reg[1];
    assign ins = hdr_reg[2];
    assign p1  = hdr_reg[3];
    assign p2  = hdr_reg[4];
    assign lc  = hdr_reg[5];
    assign read_end = {1'b0, p1, p2} + {9'd0, lc};
    assign file_len = (sel_reg == SEL_CC) ? 17'(CC_LEN) : 17'(NDEF_LEN);

    // Sort the finished frame and build its reply
    always_comb
    begin
        need_reply = 1'b0;
        sel_write  = 1'b0;
        sel_value  = SEL_NONE;
        desc.kind     = RK_APDU;
        desc.pcb      = PCB_I_VAL | {7'd0, pcb[0]};
        desc.sw_hi    = SW_OK_HI;
        desc.sw_lo    = SW_ZERO;
        desc.rom_ndef = (sel_reg == SEL_NDEF);
        desc.offset   = p2[5:0];
        desc.length   = 6'd0;
        if ((pcb & PCB_I_MASK) == PCB_I_VAL)
        begin
            need_reply = (pos_reg >= POS_HDR);
            if (cla != CLA_ISO)
            begin
                desc.sw_hi = SW_BAD_CLA;
            end
            else if (ins == INS_SELECT)
            begin
                sel_write = 1'b1;
                if (p1 == P1_BY_NAME && p2 == P2_BY_NAME)
                begin
                    if (lc != LC_AID)
                    begin
                        desc.sw_hi = SW_BAD_LEN;
                    end
                    else if (!(aid_eq_reg && pos_reg >= POS_AID_END))
                    begin
                        desc.sw_hi = SW_NOT_FOUND;
                        desc.sw_lo = SW_NOT_FOUND_LO;
                    end
                end
                else if (p1 == P1_BY_ID && p2 == P2_BY_ID)
                begin
                    if (lc != LC_FILE_ID)
                    begin
                        desc.sw_hi = SW_BAD_LEN;
                    end
                    else if (pos_reg >= POS_ID_END && cap_reg)
                    begin
                        sel_value = SEL_CC;
                    end
                    else if (pos_reg >= POS_ID_END && ndef_reg)
                    begin
                        sel_value = SEL_NDEF;
                    end
                    else
                    begin
                        desc.sw_hi = SW_NOT_FOUND;
                        desc.sw_lo = SW_NOT_FOUND_LO;
                    end
                end
                else
                begin
                    desc.sw_hi = SW_BAD_P1P2;
                end
            end
            else if (ins == INS_READ_BIN)
            begin
                if (sel_reg != SEL_CC && sel_reg != SEL_NDEF)
                begin
                    desc.sw_hi = SW_NOT_FOUND;
                    desc.sw_lo = SW_NOT_FOUND_LO;
                end
                else if (read_end > file_len || {1'b0, lc} > 9'(REPLY_BYTES - 3))
                begin
                    desc.sw_hi = SW_BAD_LEN;
                end
                else
                begin
                    desc.length = lc[5:0];
                end
            end
            else
            begin
                desc.sw_hi = SW_BAD_INS;
            end
        end
        else if ((pcb & PCB_R_MASK) == PCB_R_VAL)
        begin
            need_reply = pcb[4];
            desc.kind  = RK_SINGLE;
            desc.pcb   = PCB_R_ACK | {7'd0, ~pcb[0]};
        end
        else if ((pcb & PCB_S_MASK) == PCB_S_VAL)
        begin
            need_reply = 1'b1;
            desc.kind  = RK_SINGLE;
            desc.pcb   = pcb;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_RECV:
            begin
                if (rx_fire && rx.rx_last)
                begin
                    state_next = FR_CLASSIFY;
                end
            end
            FR_CLASSIFY:
            begin
                if (!need_reply || push_ready)
                begin
                    state_next = FR_RECV;
                end
            end
            default: state_next = FR_RECV;
        endcase
    end

    // Outputs
    always_comb
    begin
        rx.ready   = (state_reg == FR_RECV);
        push_valid = (state_reg == FR_CLASSIFY) && need_reply;
        push_data  = desc;
        done       = (state_reg == FR_CLASSIFY) && (!need_reply || push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FR_RECV;
            pos_reg    <= '0;
            aid_eq_reg <= 1'b1;
            cap_reg    <= 1'b1;
            ndef_reg   <= 1'b1;
            sel_reg    <= SEL_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                // Return frame state to its start values
                pos_reg    <= '0;
                aid_eq_reg <= 1'b1;
                cap_reg    <= 1'b1;
                ndef_reg   <= 1'b1;
                if (need_reply && sel_write)
                begin
                    sel_reg <= sel_value;
                end
            end
            else if (rx_fire)
            begin
                if (pos_reg < POS_AID_END)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (pos_reg >= POS_HDR && pos_reg < POS_AID_END &&
                    rx.rx_byte != aid_byte(3'(pos_reg - POS_HDR)))
                begin
                    aid_eq_reg <= 1'b0;
                end
                if (pos_reg >= POS_HDR && pos_reg < POS_ID_END)
                begin
                    if (rx.rx_byte != (pos_reg[0] ? CAP_ID_LO : CAP_ID_HI))
                    begin
                        cap_reg <= 1'b0;
                    end
                    if (rx.rx_byte != (pos_reg[0] ? NDEF_ID_LO : NDEF_ID_HI))
                    begin
                        ndef_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Capture header words
    always_ff @(posedge clk)
    begin
        if (rx_fire && pos_reg < POS_HDR)
        begin
            hdr_reg[pos_reg[2:0]] <= rx.rx_byte;
        end
    end

endmodule

// ===== hdl/nfc4_queue.sv =====
// ----------------------------------------------------------------------------
// nfc4_queue
// Small FIFO of reply descriptors between the frame parser and the reply
// generator.
// ----------------------------------------------------------------------------
module nfc4_queue
    import nfc4_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  reply_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output reply_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    reply_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store descriptors
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/nfc4_back.sv =====
// ----------------------------------------------------------------------------
// nfc4_back
// Reply generator: pops a descriptor and emits the PCB word and, for an APDU
// reply, ROM data and status word through a registered output stage.
// ----------------------------------------------------------------------------
module nfc4_back
    import nfc4_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  reply_t  pop_data,
    nfc4_tx_if.source tx
);

    back_state_t state_reg, state_next;
    reply_t      desc_reg;
    logic [5:0]  idx_reg, idx_next;
    logic [5:0]  rem_reg, rem_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_last_reg, tx_last_next;
    logic        out_free;
    logic        load;

    assign out_free   = !tx_valid_reg || tx.ready;
    assign tx.valid   = tx_valid_reg;
    assign tx.tx_byte = tx_byte_reg;
    assign tx.tx_last = tx_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_PCB;
                end
            end
            BK_PCB:
            begin
                if (out_free)
                begin
                    if (desc_reg.kind == RK_SINGLE)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (desc_reg.length == 6'd0)
                    begin
                        state_next = BK_SW_HI;
                    end
                    else
                    begin
                        state_next = BK_DATA;
                    end
                end
            end
            BK_DATA:
            begin
                if (out_free && rem_reg == 6'd1)
                begin
                    state_next = BK_SW_HI;
                end
            end
            BK_SW_HI:
            begin
                if (out_free)
                begin
                    state_next = BK_SW_LO;
                end
            end
            BK_SW_LO:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop_ready    = (state_reg == BK_IDLE);
        load         = 1'b0;
        tx_byte_next = tx_byte_reg;
        tx_last_next = tx_last_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                idx_next = pop_data.offset;
                rem_next = pop_data.length;
            end
            BK_PCB:
            begin
                load         = out_free;
                tx_byte_next = desc_reg.pcb;
                tx_last_next = (desc_reg.kind == RK_SINGLE);
            end
            BK_DATA:
            begin
                load         = out_free;
                tx_byte_next = rom_byte(desc_reg.rom_ndef, idx_reg);
                tx_last_next = 1'b0;
                if (out_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
            end
            BK_SW_HI:
            begin
                load         = out_free;
                tx_byte_next = desc_reg.sw_hi;
                tx_last_next = 1'b0;
            end
            BK_SW_LO:
            begin
                load         = out_free;
                tx_byte_next = desc_reg.sw_lo;
                tx_last_next = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        if (load)
        begin
            tx_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            tx_valid_next = 1'b0;
        end
        else
        begin
            tx_valid_next = tx_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    // Hold descriptor and output word
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && pop_valid)
        begin
            desc_reg <= pop_data;
        end
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        if (load)
        begin
            tx_byte_reg <= tx_byte_next;
            tx_last_reg <= tx_last_next;
        end
    end

endmodule

// ===== hdl/nfc_type4_tag_apdu_responder_unit.sv =====
// ----------------------------------------------------------------------------
// nfc_type4_tag_apdu_responder_unit
// ISO-DEP responder for a read-only Type 4 tag with fixed CC and NDEF files.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries received frame words, PCB first, rx_last on the final word.
//   tx carries the reply frame, PCB first, tx_last on the final word; frames
//   that need no reply (short I-block, R-ACK, unknown PCB) produce nothing.
//   A word that is not the end of a frame is taken without hold-off. After
//   the final word the frame parser sorts the frame and hands the reply
//   descriptor to a two-entry queue; rx is held off while it does so. The
//   reply generator pops the descriptor and registers the first reply word
//   in its output stage, then gives one reply word per cycle while tx is
//   ready. A reply is 1 to 47 words (PCB, up to 44 data words, status word).
//   The reply generator runs from the queue on its own, so the next frame
//   can be received while a reply is still going out; when tx stalls and
//   the queue is full, rx stalls at the next frame end.
//   Reset clears the selected file, the frame parser, the queue and the
//   output stage; no reply is pending after reset.
// ----------------------------------------------------------------------------
module nfc_type4_tag_apdu_responder_unit
    import nfc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    nfc4_rx_if.sink     rx,
    nfc4_tx_if.source   tx
);

    logic   push_valid;
    logic   push_ready;
    reply_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    reply_t pop_data;

    // Parse and sort frames
    nfc4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple parser from reply generator
    nfc4_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Emit reply words
    nfc4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .tx        (tx)
    );

endmodule

// ===== hdl/nfc4_checker.sv =====
// ----------------------------------------------------------------------------
// nfc4_checker
// Port-level checks on the responder: output stall behavior, frame end
// hold-off and gap-free reply bursts.
// ----------------------------------------------------------------------------
`include "nfc_type4_tag_apdu_responder_unit_defines.svh"

module nfc4_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       rx_last,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [7:0] tx_byte,
    input logic       tx_last
);

    // Hold a stalled reply word
    `NFC4_ASSERT_NEXT(a_tx_valid_hold, tx_valid && !tx_ready, tx_valid)
    `NFC4_ASSERT_NEXT(a_tx_word_hold, tx_valid && !tx_ready,
        $stable(tx_byte) && $stable(tx_last))

    // Frame end holds rx off while the frame is sorted
    `NFC4_ASSERT_NEXT(a_rx_end_holdoff, rx_valid && rx_ready && rx_last, !rx_ready)

    // Reply words follow each other with no gap
    `NFC4_ASSERT_NEXT(a_tx_no_gap, tx_valid && tx_ready && !tx_last, tx_valid)

    // An offered reply word carries known data
    `NFC4_ASSERT_SAME(a_tx_word_known, tx_valid, !$isunknown({tx_byte, tx_last}))

endmodule

bind nfc_type4_tag_apdu_responder_unit nfc4_checker u_nfc4_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .rx_last  (rx.rx_last),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_byte  (tx.tx_byte),
    .tx_last  (tx.tx_last)
);

// ===== tb/nfc_type4_tag_apdu_responder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_type4_tag_apdu_responder_unit_test
// Self-checking bench for the Type 4 tag responder. Frames of received words
// go in through a queued driver. A predictor tracks frame and file-selection
// state and builds each expected reply. A monitor compares every reply word
// with the oldest expectation. Several idle/stall phases are run, plus a long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module nfc_type4_tag_apdu_responder_unit_test;
    import nfc4_pkg::*;

    localparam int MAX_FRAME_WORDS = 64;
    localparam int PHASE_WORDS     = 40;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 3000;

    localparam logic [7:0] BLOCK_NUM  = 8'h01;
    localparam logic [7:0] R_NACK_BIT = 8'h10;
    localparam logic [7:0] I_PCB_FREE = 8'h1d;
    localparam logic [7:0] R_PCB_FREE = 8'h19;
    localparam logic [7:0] S_PCB_FREE = 8'h38;
    localparam logic [7:0] PCB_JUNK   = 8'hff;

    localparam logic [7:0] APP_ID_WORDS [7] = '{
        8'hd2, 8'h76, 8'h00, 8'h00, 8'h85, 8'h01, 8'h01
    };
    localparam logic [7:0] CC_FILE_ID   [2] = '{CAP_ID_HI, CAP_ID_LO};
    localparam logic [7:0] NDEF_FILE_ID [2] = '{NDEF_ID_HI, NDEF_ID_LO};

    localparam logic [7:0] CAP_IMAGE [15] = '{
        8'h00, 8'h0f, 8'h20, 8'h00, 8'hff, 8'h00, 8'h36,
        8'h04, 8'h06, 8'h00, 8'h01, 8'h00, 8'h2c, 8'h00, 8'hff
    };
    localparam logic [7:0] NDEF_IMAGE [44] = '{
        8'h00, 8'h2a,
        8'hd1, 8'h01, 8'h26, 8'h55, 8'h04, 8'h67, 8'h69, 8'h74, 8'h68, 8'h75,
        8'h62, 8'h2e, 8'h63, 8'h6f, 8'h6d, 8'h2f,
        8'h67, 8'h65, 8'h6e, 8'h74, 8'h69, 8'h6c, 8'h6b, 8'h69, 8'h77, 8'h69,
        8'h2f, 8'h73, 8'h74, 8'h32, 8'h35, 8'h74,
        8'h62, 8'h5f, 8'h6b, 8'h61, 8'h6d, 8'h65, 8'h6c, 8'h65, 8'h6f, 8'h6e
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    logic clk;
    logic rst_n;

    nfc4_rx_if rx_ch ();
    nfc4_tx_if tx_ch ();

    nfc_type4_tag_apdu_responder_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // Stimulus and expectation stores
    frame_word_t frame_words_pending [$];
    frame_word_t reply_words_expected [$];
    logic [7:0]  frame_buf [$];
    int          queued_words;
    int          accepted_words;
    int          fault_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_req;

    // Predicted tag state
    int          frame_len;
    logic [7:0]  frame_hdr [6];
    logic        aid_ok;
    logic        cc_id_ok;
    logic        ndef_id_ok;
    sel_t        cur_file;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Clear the per-frame state
    task automatic clear_frame();
        frame_len  = 0;
        frame_hdr  = '{default: 8'h00};
        aid_ok     = 1'b1;
        cc_id_ok   = 1'b1;
        ndef_id_ok = 1'b1;
    endtask

    // Absorb one accepted frame word; on the frame end queue the reply words
    task automatic absorb_frame_word(input logic [7:0] b, input logic last);
        logic [7:0]  reply [$];
        logic [7:0]  pcb;
        logic [7:0]  lc;
        logic [7:0]  sw_hi;
        logic [7:0]  sw_lo;
        int          offset;
        int          file_len;
        int          k;
        frame_word_t w;
        if (frame_len < MAX_FRAME_WORDS)
        begin
            if (frame_len < 6)
                frame_hdr[frame_len] = b;
            if (frame_len >= 6 && frame_len < 13 && b != APP_ID_WORDS[frame_len - 6])
                aid_ok = 1'b0;
            if (frame_len >= 6 && frame_len < 8)
            begin
                if (b != CC_FILE_ID[frame_len - 6])
                    cc_id_ok = 1'b0;
                if (b != NDEF_FILE_ID[frame_len - 6])
                    ndef_id_ok = 1'b0;
            end
            frame_len++;
        end
        if (!last)
            return;

        pcb = frame_hdr[0];
        lc  = frame_hdr[5];
        if ((pcb & PCB_I_MASK) == PCB_I_VAL)
        begin
            if (frame_len >= 6)
            begin
                reply.push_back(PCB_I_VAL | (pcb & BLOCK_NUM));
                sw_hi = SW_OK_HI;
                sw_lo = SW_ZERO;
                if (frame_hdr[1] != CLA_ISO)
                    sw_hi = SW_BAD_CLA;
                else if (frame_hdr[2] == INS_SELECT)
                begin
                    cur_file = SEL_NONE;
                    if (frame_hdr[3] == P1_BY_NAME && frame_hdr[4] == P2_BY_NAME)
                    begin
                        if (lc != LC_AID)
                            sw_hi = SW_BAD_LEN;
                        else if (!(aid_ok && frame_len >= 13))
                        begin
                            sw_hi = SW_NOT_FOUND;
                            sw_lo = SW_NOT_FOUND_LO;
                        end
                    end
                    else if (frame_hdr[3] == P1_BY_ID && frame_hdr[4] == P2_BY_ID)
                    begin
                        if (lc != LC_FILE_ID)
                            sw_hi = SW_BAD_LEN;
                        else if (frame_len >= 8 && cc_id_ok)
                            cur_file = SEL_CC;
                        else if (frame_len >= 8 && ndef_id_ok)
                            cur_file = SEL_NDEF;
                        else
                        begin
                            sw_hi = SW_NOT_FOUND;
                            sw_lo = SW_NOT_FOUND_LO;
                        end
                    end
                    else
                        sw_hi = SW_BAD_P1P2;
                end
                else if (frame_hdr[2] == INS_READ_BIN)
                begin
                    offset   = {16'd0, frame_hdr[3], frame_hdr[4]};
                    file_len = (cur_file == SEL_CC) ? CC_LEN : NDEF_LEN;
                    if (cur_file != SEL_CC && cur_file != SEL_NDEF)
                    begin
                        sw_hi = SW_NOT_FOUND;
                        sw_lo = SW_NOT_FOUND_LO;
                    end
                    else if (offset + int'(lc) > file_len || int'(lc) > REPLY_BYTES - 3)
                        sw_hi = SW_BAD_LEN;
                    else
                    begin
                        for (k = 0; k < int'(lc); k++)
                            reply.push_back((cur_file == SEL_CC) ? CAP_IMAGE[offset + k]
                                                                 : NDEF_IMAGE[offset + k]);
                    end
                end
                else
                    sw_hi = SW_BAD_INS;
                reply.push_back(sw_hi);
                reply.push_back(sw_lo);
            end
        end
        else if ((pcb & PCB_R_MASK) == PCB_R_VAL)
        begin
            // NACK is answered by an ACK with the block number toggled
            if ((pcb & R_NACK_BIT) != 8'h00)
                reply.push_back(PCB_R_VAL | ((pcb & BLOCK_NUM) ^ BLOCK_NUM));
        end
        else if ((pcb & PCB_S_MASK) == PCB_S_VAL)
            reply.push_back(pcb);

        for (k = 0; k < reply.size(); k++)
        begin
            w.data = reply[k];
            w.last = (k == reply.size() - 1);
            reply_words_expected.push_back(w);
        end
        clear_frame();
    endtask

    // Driver: present pending words, predict on every accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'h00;
            rx_ch.rx_last <= 1'b0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                absorb_frame_word(rx_ch.rx_byte, rx_ch.rx_last);
                accepted_words++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (frame_words_pending.size() > 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= frame_words_pending[0].data;
                    rx_ch.rx_last <= frame_words_pending[0].last;
                    void'(frame_words_pending.pop_front());
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long counted hold-off on request
    int hold_ack;
    int hold_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_ch.ready <= 1'b0;
            hold_ack    <= 0;
            hold_left   <= 0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack    <= hold_req;
            hold_left   <= LONG_HOLD;
            tx_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left   <= hold_left - 1;
            tx_ch.ready <= 1'b0;
        end
        else
            tx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check each reply word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (reply_words_expected.size() == 0)
            begin
                $error("unexpected reply word: tx_byte %02h tx_last %0b",
                       tx_ch.tx_byte, tx_ch.tx_last);
                fault_count++;
            end
            else
            begin
                if (tx_ch.tx_byte !== reply_words_expected[0].data)
                begin
                    $error("tx_byte: expected %02h, got %02h",
                           reply_words_expected[0].data, tx_ch.tx_byte);
                    fault_count++;
                end
                if (tx_ch.tx_last !== reply_words_expected[0].last)
                begin
                    $error("tx_last: expected %0b, got %0b",
                           reply_words_expected[0].last, tx_ch.tx_last);
                    fault_count++;
                end
                void'(reply_words_expected.pop_front());
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Move the assembled frame into the pending words, marking its end
    task automatic send_frame();
        frame_word_t w;
        int          k;
        for (k = 0; k < frame_buf.size(); k++)
        begin
            w.data = frame_buf[k];
            w.last = (k == frame_buf.size() - 1);
            frame_words_pending.push_back(w);
        end
        queued_words += frame_buf.size();
        frame_buf.delete();
    endtask

    // Start an I-block: random block number and spare bits, then the header
    task automatic start_apdu(input logic [7:0] cla, input logic [7:0] ins,
                              input logic [7:0] p1, input logic [7:0] p2,
                              input logic [7:0] lc);
        frame_buf.push_back(PCB_I_VAL | (rand_byte() & I_PCB_FREE));
        frame_buf.push_back(cla);
        frame_buf.push_back(ins);
        frame_buf.push_back(p1);
        frame_buf.push_back(p2);
        frame_buf.push_back(lc);
    endtask

    // Queue one random frame, or a select followed by reads
    task automatic add_random_frame();
        int         pick;
        int         r;
        int         n;
        int         f;
        int         off;
        int         le;
        int         k;
        logic [7:0] b;
        logic [7:0] p1;
        logic [7:0] p2;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            // select by file id, then read from it
            r = $urandom_range(9);
            start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, P2_BY_ID,
                       ($urandom_range(9) == 0) ? rand_byte() : LC_FILE_ID);
            f = CC_LEN;
            if (r < 4)
            begin
                frame_buf.push_back(CAP_ID_HI);
                frame_buf.push_back(CAP_ID_LO);
            end
            else if (r < 8)
            begin
                frame_buf.push_back(NDEF_ID_HI);
                frame_buf.push_back(NDEF_ID_LO);
                f = NDEF_LEN;
            end
            else if (r == 8)
            begin
                frame_buf.push_back(rand_byte());
                frame_buf.push_back(rand_byte());
            end
            else if ($urandom_range(1) == 1)
                frame_buf.push_back(CAP_ID_HI);
            send_frame();
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
            begin
                r   = $urandom_range(9);
                off = $urandom_range(0, f);
                le  = $urandom_range(0, f - off);
                if (r == 6)
                    le = 0;
                else if (r == 7)
                    le = f - off + 1 + $urandom_range(0, 8);
                else if (r == 8)
                begin
                    off = 0;
                    le  = $urandom_range(REPLY_BYTES - 2, 255);
                end
                else if (r == 9)
                begin
                    off = $urandom_range(0, 65535);
                    le  = $urandom_range(0, 255);
                end
                start_apdu(CLA_ISO, INS_READ_BIN, 8'(off >> 8), 8'(off), 8'(le));
                send_frame();
            end
        end
        else if (pick < 45)
        begin
            // select by application id: good, corrupted, truncated, bad length
            r = $urandom_range(9);
            start_apdu(CLA_ISO, INS_SELECT, P1_BY_NAME, P2_BY_NAME,
                       (r == 9) ? rand_byte() : LC_AID);
            n  = (r == 8) ? $urandom_range(0, 6) : 7;
            le = $urandom_range(0, 6);
            for (k = 0; k < n; k++)
            begin
                b = APP_ID_WORDS[k];
                if (r == 7 && k == le)
                    b = b ^ 8'(1 << $urandom_range(7));
                frame_buf.push_back(b);
            end
            if ($urandom_range(3) == 0)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 53)
        begin
            // read on whatever is selected now
            off = $urandom_range(0, NDEF_LEN);
            le  = $urandom_range(0, NDEF_LEN - off);
            start_apdu(CLA_ISO, INS_READ_BIN, 8'(off >> 8), 8'(off), 8'(le));
            send_frame();
        end
        else if (pick < 59)
        begin
            // unknown class
            start_apdu(8'($urandom_range(1, 255)),
                       ($urandom_range(1) == 1) ? INS_SELECT : rand_byte(),
                       rand_byte(), rand_byte(), rand_byte());
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 65)
        begin
            // unknown instruction
            b = rand_byte();
            if (b == INS_SELECT || b == INS_READ_BIN)
                b = b ^ 8'h01;
            start_apdu(CLA_ISO, b, rand_byte(), rand_byte(), rand_byte());
            send_frame();
        end
        else if (pick < 70)
        begin
            // select with an unsupported P1P2
            p1 = rand_byte();
            p2 = rand_byte();
            if ((p1 == P1_BY_NAME && p2 == P2_BY_NAME) || (p1 == P1_BY_ID && p2 == P2_BY_ID))
                p2 = p2 ^ 8'h80;
            start_apdu(CLA_ISO, INS_SELECT, p1, p2, rand_byte());
            frame_buf.push_back(rand_byte());
            frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 78)
        begin
            frame_buf.push_back(PCB_R_VAL | (rand_byte() & R_PCB_FREE));
            if ($urandom_range(3) == 0)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 85)
        begin
            frame_buf.push_back(PCB_S_VAL | (rand_byte() & S_PCB_FREE));
            if ($urandom_range(3) == 0)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 90)
        begin
            // short I-block
            n = $urandom_range(1, 5);
            frame_buf.push_back(PCB_I_VAL | (rand_byte() & I_PCB_FREE));
            for (k = 1; k < n; k++)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 96)
        begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else if (pick < 98)
        begin
            // long frame: good application select padded to at least the frame limit
            start_apdu(CLA_ISO, INS_SELECT, P1_BY_NAME, P2_BY_NAME, LC_AID);
            for (k = 0; k < 7; k++)
                frame_buf.push_back(APP_ID_WORDS[k]);
            n = $urandom_range(MAX_FRAME_WORDS, MAX_FRAME_WORDS + 16);
            while (frame_buf.size() < n)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
        else
        begin
            start_apdu(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
            n = $urandom_range(0, 8);
            for (k = 0; k < n; k++)
                frame_buf.push_back(rand_byte());
            send_frame();
        end
    endtask

    // Hold until every word is taken and every reply word has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_words != queued_words || reply_words_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    int phase;
    int phase_start;
    int k;
    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        rx_ch.rx_last  = 1'b0;
        tx_ch.ready    = 1'b0;
        queued_words   = 0;
        accepted_words = 0;
        fault_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        cur_file       = SEL_NONE;
        clear_frame();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each block kind, a short I-block, read with and without selection
        frame_buf.push_back(PCB_S_VAL);
        send_frame();
        frame_buf.push_back(PCB_R_VAL | R_NACK_BIT);
        send_frame();
        frame_buf.push_back(PCB_R_ACK | BLOCK_NUM);
        send_frame();
        frame_buf.push_back(PCB_JUNK);
        send_frame();
        frame_buf.push_back(PCB_I_VAL);
        frame_buf.push_back(CLA_ISO);
        frame_buf.push_back(INS_SELECT);
        send_frame();
        start_apdu(CLA_ISO, INS_READ_BIN, 8'h00, 8'h00, 8'(CC_LEN));
        send_frame();
        start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, P2_BY_ID, LC_FILE_ID);
        frame_buf.push_back(CAP_ID_HI);
        frame_buf.push_back(CAP_ID_LO);
        send_frame();
        start_apdu(CLA_ISO, INS_READ_BIN, 8'h00, 8'h00, 8'(CC_LEN));
        send_frame();
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalling, both
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 67 : (phase == 3) ? 10 : 0;
            recv_stall_pct = (phase == 2) ? 67 : (phase == 3) ? 10 : 0;
            phase_start    = queued_words;
            while (queued_words - phase_start < PHASE_WORDS)
                add_random_frame();
            wait_drained();
        end

        // Back-pressure: hold the receiver off while short frames keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        for (k = 0; k < 16; k++)
        begin
            if (k % 2 == 0)
                frame_buf.push_back(PCB_S_VAL | (rand_byte() & S_PCB_FREE));
            else
            begin
                start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, P2_BY_ID, LC_FILE_ID);
                frame_buf.push_back(NDEF_ID_HI);
                frame_buf.push_back(NDEF_ID_LO);
            end
            send_frame();
        end
        wait_drained();

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== nfc_type4_tag_apdu_responder_unit.f =====
+incdir+hdl
hdl/nfc4_pkg.sv
hdl/nfc4_rx_if.sv
hdl/nfc4_tx_if.sv
hdl/nfc4_front.sv
hdl/nfc4_queue.sv
hdl/nfc4_back.sv
hdl/nfc_type4_tag_apdu_responder_unit.sv
hdl/nfc4_checker.sv
tb/nfc_type4_tag_apdu_responder_unit_test.sv
